// ----- hw/rtl/lru_writeback_block_cache_defines.svh -----
// Assertion macros shared by the block cache directory RTL.
`ifndef LRU_WRITEBACK_BLOCK_CACHE_DEFINES_SVH
`define LRU_WRITEBACK_BLOCK_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lbc_pkg.sv -----
// Shared types and constants of the LRU write-back block cache directory.
`default_nettype none

package lbc_pkg;

  localparam int unsigned NUM_BUFFERS_DEF       = 16;
  localparam int unsigned BLOCK_NUMBER_BITS_DEF = 24;

  // Fixed field widths of the stream payloads
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned BLK_FIELD_W  = 24;
  localparam int unsigned SLOT_FIELD_W = 4;

  localparam int unsigned IN_TDATA_W    = ((BLK_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W  = 1 + SLOT_FIELD_W + 1 + 1 + BLK_FIELD_W + SLOT_FIELD_W;
  localparam int unsigned OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ     = 2'd0,
    MODE_WRITE    = 2'd1,
    MODE_SYNC_ONE = 2'd2,
    MODE_SYNC_ALL = 2'd3
  } lbc_mode_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic req_load;    // capture the incoming request
    logic cmp_en;      // register the tag match
    logic upd_en;      // update directory and load a read/write/sync-one result
    logic sync_pop;    // write back the oldest dirty slot
    logic sync_empty;  // load the result of a sync-all with nothing dirty
  } lbc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    lbc_mode_e mode;
    logic      cnt_zero;
    logic      cnt_one;
    logic      out_free;
  } lbc_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lru_writeback_block_cache.sv -----
// Directory of a fully associative block buffer cache with LRU replacement and write-back.
// Each request names a disk block. Read, write and sync-block first capture the request,
// then register one parallel compare of all tag cells, then update the directory and the
// recency and dirty lists and load the result into the output register. A sync-all loads
// its first result after the compare and then one result per cycle while the output
// register is free, since the dirty list is drained one entry per cycle through the single
// tag read port. The next request is accepted in the cycle after the last result has been
// placed in the output register, even if that result has not yet been taken; a full output
// register stalls the update. There is no clearing pass after reset.
`default_nettype none
`include "lru_writeback_block_cache_defines.svh"

module lru_writeback_block_cache import lbc_pkg::*; #(
  parameter int unsigned NUM_BUFFERS       = NUM_BUFFERS_DEF,
  parameter int unsigned BLOCK_NUMBER_BITS = BLOCK_NUMBER_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // block_number
  input  logic [MODE_W-1:0]      s_axis_tuser,   // mode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit, slot, fetch_needed, writeback_valid, writeback_block, writeback_slot
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  lbc_cmd_t cmd;
  lbc_sts_t sts;

  logic                    hit, fetch_needed, writeback_valid;
  logic [SLOT_FIELD_W-1:0] slot, writeback_slot;
  logic [BLK_FIELD_W-1:0]  writeback_block;

  lbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lbc_dp #(
    .NumBuffers (NUM_BUFFERS),
    .TagW       (BLOCK_NUMBER_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mode_i            (s_axis_tuser),
    .block_number_i    (s_axis_tdata[BLK_FIELD_W-1:0]),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .hit_o             (hit),
    .slot_o            (slot),
    .fetch_needed_o    (fetch_needed),
    .writeback_valid_o (writeback_valid),
    .writeback_block_o (writeback_block),
    .writeback_slot_o  (writeback_slot),
    .last_o            (m_axis_tlast)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, writeback_slot, writeback_block,
                         writeback_valid, fetch_needed, slot, hit};

  `LBC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")
  `LBC_ASSERT_NOW(a_nonlast_is_writeback, m_axis_tvalid && !m_axis_tlast, writeback_valid, "non-final result without write-back")
  `LBC_ASSERT_NOW(a_fetch_only_on_miss, m_axis_tvalid && fetch_needed, !hit, "fetch requested on a hit")
  `LBC_ASSERT_NEXT(a_drain_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "sync-all drain stalled")

endmodule

`default_nettype wire

// ----- hw/rtl/lbc_order_list.sv -----
// Ordered slot list: remove one entry by value, close the gap, write at a position.
`default_nettype none

module lbc_order_list import lbc_pkg::*; #(
  parameter int unsigned Depth = NUM_BUFFERS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rm_en_i,
  input  logic [$clog2(Depth)-1:0]   rm_val_i,
  input  logic [$clog2(Depth+1)-1:0] limit_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(Depth)-1:0]   wr_pos_i,
  input  logic [$clog2(Depth)-1:0]   wr_val_i,
  output logic [$clog2(Depth)-1:0]   front_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [IdxW-1:0] list_q [Depth];
  logic [IdxW-1:0] list_d [Depth];
  logic [IdxW-1:0] up     [Depth];
  logic            found;
  logic [IdxW-1:0] pos;

  // Entries are distinct within the limit, so the match is one-hot
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int j = 0; j < Depth; j++) begin
      if (rm_en_i && (CntW'(j) < limit_i) && (list_q[j] == rm_val_i)) begin
        found = 1'b1;
        pos   = pos | IdxW'(j);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < Depth - 1; j++) begin
      up[j] = list_q[j + 1];
    end
    up[Depth-1] = list_q[Depth-1];
  end

  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      list_d[j] = list_q[j];
      if (found && (IdxW'(j) >= pos)) begin
        list_d[j] = up[j];
      end
      if (wr_en_i && (IdxW'(j) == wr_pos_i)) begin
        list_d[j] = wr_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    list_q <= list_d;
  end

  assign front_o = list_q[0];

endmodule

`default_nettype wire

// ----- hw/rtl/lbc_dp.sv -----
// Datapath: tag cells, valid/dirty bits, recency and dirty lists, result register.
`default_nettype none

module lbc_dp import lbc_pkg::*; #(
  parameter int unsigned NumBuffers = NUM_BUFFERS_DEF,
  parameter int unsigned TagW       = BLOCK_NUMBER_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lbc_cmd_t                cmd_i,
  output lbc_sts_t                sts_o,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic [BLK_FIELD_W-1:0]  block_number_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic                    hit_o,
  output logic [SLOT_FIELD_W-1:0] slot_o,
  output logic                    fetch_needed_o,
  output logic                    writeback_valid_o,
  output logic [BLK_FIELD_W-1:0]  writeback_block_o,
  output logic [SLOT_FIELD_W-1:0] writeback_slot_o,
  output logic                    last_o
);

  localparam int unsigned SlotW = $clog2(NumBuffers);
  localparam int unsigned CntW  = $clog2(NumBuffers + 1);

  // Request and lookup
  lbc_mode_e       mode_q;
  logic [TagW-1:0] blk_q;
  logic            hit_q, hit_d;
  logic [SlotW-1:0] found_q, found_d;

  // Directory
  logic [TagW-1:0]       tag_q [NumBuffers];
  logic [NumBuffers-1:0] valid_q, valid_d;
  logic [NumBuffers-1:0] dirty_q, dirty_d;
  logic [CntW-1:0]       used_q, used_d;
  logic [CntW-1:0]       dcnt_q, dcnt_d;

  // Result register
  logic                    out_valid_q, out_valid_d;
  logic                    o_hit_q, o_hit_d;
  logic [SLOT_FIELD_W-1:0] o_slot_q, o_slot_d;
  logic                    o_fetch_q, o_fetch_d;
  logic                    o_wbv_q, o_wbv_d;
  logic [BLK_FIELD_W-1:0]  o_wbb_q, o_wbb_d;
  logic [SLOT_FIELD_W-1:0] o_wbs_q, o_wbs_d;
  logic                    o_last_q, o_last_d;

  logic             full, is_rw, is_write, was_dirty, load, out_free;
  logic [SlotW-1:0] victim, rd_addr, rec_front, dirty_front;
  logic [TagW-1:0]  tag_rd;
  logic [CntW-1:0]  used_new;
  logic             d_rm, d_app, r_en;

  // Compare every tag cell against the request
  always_comb begin
    hit_d   = 1'b0;
    found_d = '0;
    for (int i = 0; i < NumBuffers; i++) begin
      if (valid_q[i] && (tag_q[i] == blk_q)) begin
        hit_d   = 1'b1;
        found_d = found_d | SlotW'(i);
      end
    end
  end

  assign full     = (used_q == CntW'(NumBuffers));
  assign is_rw    = (mode_q == MODE_READ) || (mode_q == MODE_WRITE);
  assign is_write = (mode_q == MODE_WRITE);
  assign used_new = (hit_q || full) ? used_q : used_q + CntW'(1);

  // Hit slot, else next free slot, else least recently used
  always_comb begin
    priority if (hit_q) begin
      victim = found_q;
    end else if (!full) begin
      victim = used_q[SlotW-1:0];
    end else begin
      victim = rec_front;
    end
  end

  assign rd_addr   = cmd_i.sync_pop ? dirty_front : victim;
  assign tag_rd    = tag_q[rd_addr];
  assign was_dirty = dirty_q[victim];

  // Dirty list edits
  always_comb begin
    d_rm  = 1'b0;
    d_app = 1'b0;
    if (cmd_i.sync_pop) begin
      d_rm = 1'b1;
    end else if (cmd_i.upd_en) begin
      if (is_rw) begin
        d_rm  = was_dirty && !hit_q;
        d_app = is_write && (!was_dirty || !hit_q);
      end else begin
        d_rm  = hit_q && was_dirty;
      end
    end
  end

  assign dcnt_d = dcnt_q - CntW'(d_rm) + CntW'(d_app);
  assign r_en   = cmd_i.upd_en && is_rw;
  assign used_d = r_en ? used_new : used_q;

  lbc_order_list #(
    .Depth (NumBuffers)
  ) u_recency (
    .clk_i    (clk_i),
    .rm_en_i  (r_en),
    .rm_val_i (victim),
    .limit_i  (used_new),
    .wr_en_i  (r_en),
    .wr_pos_i (SlotW'(used_new - CntW'(1))),
    .wr_val_i (victim),
    .front_o  (rec_front)
  );

  lbc_order_list #(
    .Depth (NumBuffers)
  ) u_dirty (
    .clk_i    (clk_i),
    .rm_en_i  (d_rm),
    .rm_val_i (cmd_i.sync_pop ? dirty_front : victim),
    .limit_i  (dcnt_q),
    .wr_en_i  (d_app),
    .wr_pos_i (SlotW'(dcnt_q - CntW'(d_rm))),
    .wr_val_i (victim),
    .front_o  (dirty_front)
  );

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    if (cmd_i.upd_en) begin
      if (is_rw) begin
        valid_d[victim] = 1'b1;
        dirty_d[victim] = is_write || (hit_q && was_dirty);
      end else if (hit_q) begin
        dirty_d[victim] = 1'b0;
      end
    end
    if (cmd_i.sync_pop) begin
      dirty_d[dirty_front] = 1'b0;
    end
  end

  // Result of the current command
  always_comb begin
    o_hit_d   = 1'b0;
    o_slot_d  = '0;
    o_fetch_d = 1'b0;
    o_wbv_d   = 1'b0;
    o_wbb_d   = '0;
    o_wbs_d   = '0;
    o_last_d  = 1'b1;
    if (cmd_i.sync_pop) begin
      o_wbv_d  = 1'b1;
      o_wbb_d  = BLK_FIELD_W'(tag_rd);
      o_wbs_d  = SLOT_FIELD_W'(dirty_front);
      o_last_d = (dcnt_q == CntW'(1));
    end else if (cmd_i.upd_en) begin
      if (is_rw || hit_q) begin
        o_hit_d  = hit_q;
        o_slot_d = SLOT_FIELD_W'(victim);
      end
      o_fetch_d = !hit_q && (mode_q == MODE_READ);
      o_wbv_d   = d_rm;
      if (d_rm) begin
        o_wbb_d = BLK_FIELD_W'(tag_rd);
        o_wbs_d = SLOT_FIELD_W'(victim);
      end
    end
  end

  assign load        = cmd_i.upd_en || cmd_i.sync_pop || cmd_i.sync_empty;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      dirty_q     <= '0;
      used_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      used_q      <= used_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      mode_q <= lbc_mode_e'(mode_i);
      blk_q  <= TagW'(block_number_i);
    end
    if (cmd_i.cmp_en) begin
      hit_q   <= hit_d;
      found_q <= found_d;
    end
    if (r_en && !hit_q) begin
      tag_q[victim] <= blk_q;
    end
    if (load) begin
      o_hit_q   <= o_hit_d;
      o_slot_q  <= o_slot_d;
      o_fetch_q <= o_fetch_d;
      o_wbv_q   <= o_wbv_d;
      o_wbb_q   <= o_wbb_d;
      o_wbs_q   <= o_wbs_d;
      o_last_q  <= o_last_d;
    end
  end

  assign sts_o.mode     = mode_q;
  assign sts_o.cnt_zero = (dcnt_q == '0);
  assign sts_o.cnt_one  = (dcnt_q == CntW'(1));
  assign sts_o.out_free = out_free;

  assign out_valid_o       = out_valid_q;
  assign hit_o             = o_hit_q;
  assign slot_o            = o_slot_q;
  assign fetch_needed_o    = o_fetch_q;
  assign writeback_valid_o = o_wbv_q;
  assign writeback_block_o = o_wbb_q;
  assign writeback_slot_o  = o_wbs_q;
  assign last_o            = o_last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lbc_ctrl.sv -----
// Controller: sequences request capture, tag compare, update and sync-all drain.
`default_nettype none

module lbc_ctrl import lbc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output lbc_cmd_t cmd_o,
  input  lbc_sts_t sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_SYNC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.cmp_en = 1'b1;
        state_d      = (sts_i.mode == MODE_SYNC_ALL) ? ST_SYNC : ST_UPD;
      end
      ST_UPD: begin
        // hold until the result register can take the transaction
        if (sts_i.out_free) begin
          cmd_o.upd_en = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SYNC: begin
        if (sts_i.out_free) begin
          if (sts_i.cnt_zero) begin
            cmd_o.sync_empty = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            cmd_o.sync_pop = 1'b1;
            if (sts_i.cnt_one) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench of the LRU write-back block cache directory: directed table, then random requests.
`timescale 1ns / 100ps

module tb_top;
  import lbc_pkg::*;

  localparam int unsigned NBUF        = NUM_BUFFERS_DEF;
  localparam int          RAND_ITEMS  = 250;
  localparam int          QUIET_ITEMS = 40;
  localparam int          POOL_SIZE   = 24;
  localparam int          STALL_LIMIT = 4000;
  localparam int          DRAIN_WAIT  = 20;

  typedef logic [SLOT_FIELD_W-1:0] slot_t;
  typedef logic [BLK_FIELD_W-1:0]  blk_t;

  // Field order matches tlast followed by the tdata fields, lowest bit last
  typedef struct packed {
    logic  last;
    slot_t wb_slot;
    blk_t  wb_blk;
    logic  wb_vld;
    logic  fetch;
    slot_t slot;
    logic  hit;
  } lookup_result_t;

  typedef struct packed {
    lbc_mode_e      mode;
    blk_t           blk;
    logic           check;
    lookup_result_t res;
  } req_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // Shadow directory
  logic           line_vld   [NBUF];
  blk_t           line_tag   [NBUF];
  logic           line_dirty [NBUF];
  slot_t          lru_list[$];    // least recently used at the front
  slot_t          dirty_list[$];  // oldest dirty slot at the front
  int             lines_used = 0;

  lookup_result_t pending_lookups[$];
  int             errors = 0;
  int             stall_cycles = 0;
  bit             quiet = 1'b0;

  lru_writeback_block_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void drop_slot(ref slot_t lst[$], input slot_t s);
    for (int i = 0; i < lst.size(); i++) begin
      if (lst[i] == s) begin
        lst.delete(i);
        return;
      end
    end
  endfunction

  // Apply one request to the shadow directory and queue the results it causes.
  function automatic void update_directory(lbc_mode_e mode, blk_t blk);
    int             found = -1;
    slot_t          s;
    lookup_result_t r;
    for (int i = 0; i < NBUF; i++) begin
      if (found < 0 && line_vld[i] && line_tag[i] == blk) found = i;
    end
    r = '0;
    r.last = 1'b1;
    case (mode)
      MODE_SYNC_ALL: begin
        if (dirty_list.size() == 0) pending_lookups.push_back(r);
        foreach (dirty_list[k]) begin
          r.wb_vld  = 1'b1;
          r.wb_blk  = line_tag[dirty_list[k]];
          r.wb_slot = dirty_list[k];
          r.last    = (k == dirty_list.size() - 1);
          line_dirty[dirty_list[k]] = 1'b0;
          pending_lookups.push_back(r);
        end
        dirty_list.delete();
      end
      MODE_SYNC_ONE: begin
        if (found >= 0) begin
          s = slot_t'(found);
          r.hit  = 1'b1;
          r.slot = s;
          if (line_dirty[s]) begin
            r.wb_vld  = 1'b1;
            r.wb_blk  = line_tag[s];
            r.wb_slot = s;
            line_dirty[s] = 1'b0;
            drop_slot(dirty_list, s);
          end
        end
        pending_lookups.push_back(r);
      end
      default: begin
        if (found >= 0) begin
          s = slot_t'(found);
          r.hit = 1'b1;
        end else begin
          if (lines_used < NBUF) begin
            s = slot_t'(lines_used);
            lines_used++;
          end else begin
            // evict the least recently used line, writing it back if dirty
            s = lru_list[0];
            if (line_dirty[s]) begin
              r.wb_vld  = 1'b1;
              r.wb_blk  = line_tag[s];
              r.wb_slot = s;
              line_dirty[s] = 1'b0;
              drop_slot(dirty_list, s);
            end
          end
          line_vld[s] = 1'b1;
          line_tag[s] = blk;
          r.fetch = (mode == MODE_READ);
        end
        r.slot = s;
        if (mode == MODE_WRITE && !line_dirty[s]) begin
          line_dirty[s] = 1'b1;
          dirty_list.push_back(s);
        end
        drop_slot(lru_list, s);
        lru_list.push_back(s);
        pending_lookups.push_back(r);
      end
    endcase
  endfunction

  function automatic req_row_t req(lbc_mode_e mode, blk_t blk);
    req_row_t row;
    row = '0;
    row.mode = mode;
    row.blk = blk;
    return row;
  endfunction

  function automatic req_row_t req_chk(lbc_mode_e mode, blk_t blk, logic hit, slot_t slot,
                                       logic fetch, logic wbv, blk_t wbb, slot_t wbs);
    req_row_t row;
    row = req(mode, blk);
    row.check = 1'b1;
    row.res = '{last: 1'b1, wb_slot: wbs, wb_blk: wbb, wb_vld: wbv, fetch: fetch,
                slot: slot, hit: hit};
    return row;
  endfunction

  task automatic send_request(input req_row_t row);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.blk;
    s_axis_tuser  <= row.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    update_directory(row.mode, row.blk);
    // directed rows with a hand-written result replace the predicted one
    if (row.check) begin
      void'(pending_lookups.pop_back());
      pending_lookups.push_back(row.res);
    end
  endtask

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    lookup_result_t want;
    lookup_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = lookup_result_t'({m_axis_tlast, m_axis_tdata[OUT_FIELDS_W-1:0]});
      if (pending_lookups.size() == 0) begin
        $error("result with nothing pending: tdata %0h tlast %0b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        check_field("hit", want.hit, got.hit);
        check_field("slot", want.slot, got.slot);
        check_field("fetch_needed", want.fetch, got.fetch);
        check_field("writeback_valid", want.wb_vld, got.wb_vld);
        check_field("writeback_block", want.wb_blk, got.wb_blk);
        check_field("writeback_slot", want.wb_slot, got.wb_slot);
        check_field("last", want.last, got.last);
        check_field("tdata padding", 0, m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]);
      end
    end
  end

  // Receiver side: stall in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("lru_writeback_block_cache test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    req_row_t directed[$];
    blk_t     pool[POOL_SIZE];
    int       pick;
    blk_t     blk;

    for (int i = 0; i < NBUF; i++) begin
      line_vld[i]   = 1'b0;
      line_tag[i]   = '0;
      line_dirty[i] = 1'b0;
    end

    directed = '{
      req_chk(MODE_SYNC_ALL, 24'h000000, 0, 0, 0, 0, 24'h0, 0),      // nothing dirty
      req_chk(MODE_SYNC_ONE, 24'h000005, 0, 0, 0, 0, 24'h0, 0),      // absent block
      req_chk(MODE_READ,     24'h000000, 0, 0, 1, 0, 24'h0, 0),      // read miss
      req_chk(MODE_WRITE,    24'hFFFFFF, 0, 1, 0, 0, 24'h0, 0),      // write miss
      req_chk(MODE_READ,     24'hFFFFFF, 1, 1, 0, 0, 24'h0, 0),
      req_chk(MODE_SYNC_ONE, 24'hFFFFFF, 1, 1, 0, 1, 24'hFFFFFF, 1), // dirty
      req_chk(MODE_SYNC_ONE, 24'hFFFFFF, 1, 1, 0, 0, 24'h0, 0),      // now clean
      req_chk(MODE_WRITE,    24'h000000, 1, 0, 0, 0, 24'h0, 0),
      req(MODE_WRITE, 24'hAAAAAA),
      req(MODE_WRITE, 24'h555555),
      req(MODE_WRITE, 24'h800000),
      req(MODE_READ,  24'h000001),
      req(MODE_WRITE, 24'h7FFFFF),
      req(MODE_WRITE, 24'h100000),
      req(MODE_WRITE, 24'h0F0F0F),
      req(MODE_READ,  24'hF0F0F0),
      req(MODE_WRITE, 24'h00FF00),
      req(MODE_WRITE, 24'hFF00FF),
      req(MODE_WRITE, 24'h333333),
      req(MODE_WRITE, 24'hCCCCCC),
      req(MODE_WRITE, 24'h010101),
      req(MODE_WRITE, 24'hFEFEFE),
      req(MODE_READ,  24'h123456),  // all lines used: evict a clean line
      req(MODE_WRITE, 24'h654321),  // evict a dirty line
      req(MODE_SYNC_ALL, 24'h000000)
    };

    pool[0] = 24'h000000;
    pool[1] = 24'hFFFFFF;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = blk_t'($urandom);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_request(directed[i]);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      quiet = (n >= RAND_ITEMS - QUIET_ITEMS);
      // mostly reuse a small set of blocks so hits, evictions and syncs all occur
      blk = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : blk_t'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35) send_request(req(MODE_READ, blk));
      else if (pick < 70) send_request(req(MODE_WRITE, blk));
      else if (pick < 90) send_request(req(MODE_SYNC_ONE, blk));
      else send_request(req(MODE_SYNC_ALL, blk));
    end
    s_axis_tvalid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("lru_writeback_block_cache test passed");
    end else begin
      $display("lru_writeback_block_cache test failed");
    end
    $finish;
  end

endmodule
